// ===== rtl/core/slcd_pkg.sv =====
// Shared constants, types and helpers for the sync/length/checksum deframer.
package slcd_pkg;

  localparam int BUFFER_DEPTH_DEF = 40;

  localparam logic [7:0] SYNC_A  = 8'hAA;
  localparam logic [7:0] SYNC_B  = 8'h55;
  localparam logic [7:0] CHAR_P  = 8'h50;

  // last index of the "PING\n" matcher
  localparam logic [2:0] PING_LAST = 3'd4;
  localparam logic [2:0] PING_LEN  = 3'd5;

  localparam logic [2:0] KIND_BODY     = 3'd0;
  localparam logic [2:0] KIND_PONG     = 3'd1;
  localparam logic [2:0] KIND_CSUM_ERR = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_OVERSIZE = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic take;     // accept the presented byte
    logic rd;       // issue frame store read at idx
    logic load;     // load body result from read data
    logic advance;  // step idx to next body byte
  } slcd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic burst;     // presented byte completes a good frame with a body
    logic res_valid; // result register occupied
    logic res_taken; // result transaction this cycle
    logic idx_last;  // idx points at the final body byte
  } slcd_stat_t;

  function automatic logic [7:0] ping_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h50; // P
      3'd1:    c = 8'h49; // I
      3'd2:    c = 8'h4E; // N
      3'd3:    c = 8'h47; // G
      3'd4:    c = 8'h0A; // newline
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/slcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module slcd_ram import slcd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/slcd_ctrl.sv =====
// Controller: input handshake and body read-out sequencing.
module slcd_ctrl import slcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  slcd_stat_t stat,
  output slcd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state, state_next;

  assign rx_stall = (state != ST_IDLE) || stat.res_valid;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = rx_valid && !rx_stall;
        if (cmd.take && stat.burst) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (stat.res_taken) begin
          if (stat.idx_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/slcd_datapath.sv =====
// Datapath: ping matcher, frame parser registers, frame store and result register.
module slcd_datapath import slcd_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  slcd_cmd_t  cmd,
  output slcd_stat_t stat,
  input  logic [7:0] rx_byte,
  input  logic       res_stall,
  output logic       res_valid,
  output logic [2:0] kind,
  output logic [7:0] body_byte,
  output logic [7:0] position,
  output logic [7:0] frame_length,
  output logic       last
);

  localparam int         AW     = $clog2(BUFFER_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  logic [7:0] frame_position, frame_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] length_byte, length_byte_next;
  logic [2:0] ping_progress, ping_progress_next;
  logic [7:0] idx;

  logic       ping_hit, pong, oversize, single, burst, wr_en, idx_last;
  logic [2:0] single_kind;
  logic [7:0] rd_data;
  logic       res_taken;

  assign res_taken = res_valid && !res_stall;
  assign idx_last  = ({1'b0, idx} + 9'd2) == {1'b0, length_byte};
  assign oversize  = {1'b0, length_byte} > DEPTH9;

  always_comb begin
    ping_progress_next  = ping_progress;
    frame_position_next = frame_position;
    running_sum_next    = running_sum;
    length_byte_next    = length_byte;
    pong                = 1'b0;
    single              = 1'b0;
    single_kind         = KIND_EMPTY;
    burst               = 1'b0;
    wr_en               = 1'b0;

    ping_hit = (ping_progress < PING_LEN) && (rx_byte == ping_char(ping_progress));
    if (ping_hit) begin
      if (ping_progress == PING_LAST) begin
        pong                = 1'b1;
        ping_progress_next  = 3'd0;
      end else begin
        ping_progress_next = ping_progress + 3'd1;
      end
    end else begin
      ping_progress_next = (rx_byte == CHAR_P) ? 3'd1 : 3'd0;
    end

    if (pong) begin
      frame_position_next = 8'd0;
      single              = 1'b1;
      single_kind         = KIND_PONG;
    end else if (frame_position == 8'd0) begin
      if (rx_byte == SYNC_A) begin
        frame_position_next = 8'd1;
      end
    end else if (frame_position == 8'd1) begin
      frame_position_next = (rx_byte == SYNC_B) ? 8'd2 : 8'd0;
    end else if (frame_position == 8'd2) begin
      length_byte_next    = rx_byte;
      running_sum_next    = 8'hFF + rx_byte; // AA + 55 folded in
      frame_position_next = 8'd3;
    end else if (({1'b0, frame_position} + 9'd1) < {1'b0, length_byte}) begin
      if (!oversize && ({1'b0, frame_position} < DEPTH9)) begin
        wr_en            = 1'b1;
        running_sum_next = running_sum + rx_byte;
      end
      frame_position_next = frame_position + 8'd1;
    end else begin
      // checksum byte
      frame_position_next = 8'd0;
      if (oversize) begin
        single      = 1'b1;
        single_kind = KIND_OVERSIZE;
      end else if (rx_byte != running_sum) begin
        single      = 1'b1;
        single_kind = KIND_CSUM_ERR;
      end else if (length_byte <= 8'd4) begin
        single      = 1'b1;
        single_kind = KIND_EMPTY;
      end else begin
        burst = 1'b1;
      end
    end
  end

  assign stat = '{burst: burst, res_valid: res_valid, res_taken: res_taken,
                  idx_last: idx_last};

  slcd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.take && wr_en),
    .waddr(frame_position[AW-1:0]),
    .wdata(rx_byte),
    .re   (cmd.rd),
    .raddr(idx[AW-1:0]),
    .rdata(rd_data)
  );

  // parser and matcher state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 8'd0;
      running_sum    <= 8'd0;
      length_byte    <= 8'd0;
      ping_progress  <= 3'd0;
    end else if (cmd.take) begin
      frame_position <= frame_position_next;
      running_sum    <= running_sum_next;
      length_byte    <= length_byte_next;
      ping_progress  <= ping_progress_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && burst) begin
      idx <= 8'd3;
    end else if (cmd.advance) begin
      idx <= idx + 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((cmd.take && single) || cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_taken) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && single) begin
      kind         <= single_kind;
      body_byte    <= 8'd0;
      position     <= pong ? 8'd0 : frame_position;
      frame_length <= pong ? 8'd0 : length_byte;
      last         <= 1'b1;
    end else if (cmd.load) begin
      kind         <= KIND_BODY;
      body_byte    <= rd_data;
      position     <= idx;
      frame_length <= length_byte;
      last         <= idx_last;
    end
  end

endmodule

// ===== rtl/core/sync_length_checksum_deframer_top.sv =====
// Top level of the sync/length/checksum deframer with "PING\n" detection.
// Results: a single result (pong, checksum error, empty, oversize) can be taken in the
//   cycle after its byte; each body result passes through the read and load states after the
//   checksum byte or the previous taken result, so a frame of length L gives L-4 of them.
// Throughput: one byte per cycle while idle with no result pending; rx stalls otherwise.
// Reset (rst, synchronous): parser hunting, matcher and sums cleared, no result pending.
module sync_length_checksum_deframer_top import slcd_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF  // 8 .. 256
) (
  input  logic       clk,
  input  logic       rst,
  // received byte channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] kind,
  output logic [7:0] body_byte,
  output logic [7:0] position,
  output logic [7:0] frame_length,
  output logic       last
);

  slcd_cmd_t  cmd;
  slcd_stat_t stat;

  // Controller owns the handshake on rx and the read-out sequence of a good
  // frame; all arithmetic and storage sit in the datapath.
  slcd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Datapath: ping matcher runs ahead of the parser; a completed "PING\n"
  // wins and sends the parser back to hunting. Body bytes 3..L-2 go to the
  // frame store unless the frame is oversize.
  slcd_datapath #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rx_byte     (rx_byte),
    .res_stall   (res_stall),
    .res_valid   (res_valid),
    .kind        (kind),
    .body_byte   (body_byte),
    .position    (position),
    .frame_length(frame_length),
    .last        (last)
  );

endmodule

// ===== rtl/core/slcd_checker.sv =====
// Port-level checker for the deframer top, bound to every instance.
module slcd_checker import slcd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rx_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] kind,
  input logic [7:0] body_byte,
  input logic [7:0] position,
  input logic [7:0] frame_length,
  input logic       last
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(body_byte)
      && $stable(position) && $stable(frame_length) && $stable(last))
    else $error("stalled result changed");

  // no byte taken while a result is pending
  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> rx_stall)
    else $error("input accepted with result pending");

  // non-body results carry no byte and close the transaction group
  a_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind != KIND_BODY) |-> (body_byte == 8'd0) && last)
    else $error("bad single result");

  // pong carries no frame context
  a_pong: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_PONG) |-> (position == 8'd0) && (frame_length == 8'd0))
    else $error("pong with frame fields");

  // body positions lie in 3..L-2 and last marks L-2
  a_body_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_BODY) |-> (position >= 8'd3)
      && (({1'b0, position} + 9'd2) <= {1'b0, frame_length})
      && (last == (({1'b0, position} + 9'd2) == {1'b0, frame_length})))
    else $error("body position out of range");

endmodule

bind sync_length_checksum_deframer_top slcd_checker u_slcd_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_stall    (rx_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .kind        (kind),
  .body_byte   (body_byte),
  .position    (position),
  .frame_length(frame_length),
  .last        (last)
);

// ===== tb/sync_length_checksum_deframer_top_test.sv =====
// Self-checking testbench for the sync/length/checksum deframer with PING detection.
module sync_length_checksum_deframer_top_test;
  import slcd_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int BUF_DEPTH  = BUFFER_DEPTH_DEF;
  localparam int NUM_ITEMS  = 330;
  localparam int MAX_CYCLES = 1_000_000;
  localparam int ERR_SHOWN  = 10;

  // "PING\n", first character in the low byte
  localparam logic [39:0] PING_TEXT = {8'h0A, 8'h47, 8'h4E, 8'h49, 8'h50};

  // Body content modes for generated frames
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] body_byte;
    logic [7:0] position;
    logic [7:0] frame_length;
    logic       last;
  } deframe_res_t;

  // One received byte waiting to be sent, with its idling phase and an
  // optional hold-off until all outstanding results have drained
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] phase;
    logic       hold;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] body_byte;
  logic [7:0] position;
  logic [7:0] frame_length;
  logic       last;

  rx_item_t     rx_pending_q[$];
  deframe_res_t frame_result_q[$];

  // Predictor state, mirrors the parser inside the block
  logic [7:0] frm_pos   = 8'd0;
  logic [7:0] run_sum   = 8'd0;
  logic [7:0] len_byte  = 8'd0;
  logic [7:0] frame_mem [BUF_DEPTH];
  logic [2:0] ping_idx  = 3'd0;

  // Stimulus generation state
  logic [1:0] gen_phase = 2'd0;
  logic       gen_hold  = 1'b0;
  int         gen_count = 0;

  logic [1:0] cur_phase = 2'd0;
  rx_item_t   drv_item;
  int         err_count = 0;

  sync_length_checksum_deframer_top #(
    .BUFFER_DEPTH (BUF_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .body_byte    (body_byte),
    .position     (position),
    .frame_length (frame_length),
    .last         (last)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void push_frame_result(input logic [2:0] k, input logic [7:0] b,
                                            input logic [7:0] p, input logic [7:0] l);
    deframe_res_t r;
    r.kind         = k;
    r.body_byte    = b;
    r.position     = p;
    r.frame_length = l;
    r.last         = 1'b0;
    frame_result_q.push_back(r);
  endfunction

  // Advance the predictor by one accepted byte and queue the results it causes
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [7:0]   pos;
    logic [7:0]   len;
    logic         over;
    int           n_before;
    int           i;
    deframe_res_t tail;
    pos      = frm_pos;
    len      = len_byte;
    n_before = frame_result_q.size();

    // PING matcher sees every byte first; its final newline never
    // reaches the frame parser
    if (ping_idx < PING_LEN && b == PING_TEXT[ping_idx*8 +: 8]) begin
      ping_idx = ping_idx + 3'd1;
      if (ping_idx == PING_LEN) begin
        ping_idx = 3'd0;
        frm_pos  = 8'd0;
        push_frame_result(KIND_PONG, 8'd0, 8'd0, 8'd0);
        tail = frame_result_q.pop_back();
        tail.last = 1'b1;
        frame_result_q.push_back(tail);
        return;
      end
    end else begin
      ping_idx = (b == CHAR_P) ? 3'd1 : 3'd0;
    end

    // header: AA, then 55, then the length byte
    if (pos == 8'd0) begin
      if (b == SYNC_A) begin
        frame_mem[0] = b;
        frm_pos = 8'd1;
      end
      return;
    end
    if (pos == 8'd1) begin
      if (b == SYNC_B) begin
        frame_mem[1] = b;
        frm_pos = 8'd2;
      end else begin
        frm_pos = 8'd0;
      end
      return;
    end
    if (pos == 8'd2) begin
      frame_mem[2] = b;
      len_byte = b;
      run_sum  = 8'hFF + b;
      frm_pos  = 8'd3;
      return;
    end

    over = int'(len) > BUF_DEPTH;
    if (int'(pos) + 1 < int'(len)) begin
      // body byte; oversize frames are only counted through
      if (!over && int'(pos) < BUF_DEPTH) begin
        frame_mem[pos] = b;
        run_sum = run_sum + b;
      end
      frm_pos = pos + 8'd1;
      return;
    end

    // checksum byte closes the frame
    frm_pos = 8'd0;
    if (over) begin
      push_frame_result(KIND_OVERSIZE, 8'd0, pos, len);
    end else if (b != run_sum) begin
      push_frame_result(KIND_CSUM_ERR, 8'd0, pos, len);
    end else if (int'(len) <= 4) begin
      push_frame_result(KIND_EMPTY, 8'd0, pos, len);
    end else begin
      for (i = 3; i + 2 <= int'(len) && i < BUF_DEPTH; i++)
        push_frame_result(KIND_BODY, frame_mem[i], 8'(i), len);
    end
    if (frame_result_q.size() > n_before) begin
      tail = frame_result_q.pop_back();
      tail.last = 1'b1;
      frame_result_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  function automatic void push_rx(input logic [7:0] b);
    rx_item_t it;
    it.data  = b;
    it.phase = gen_phase;
    it.hold  = gen_hold;
    rx_pending_q.push_back(it);
    gen_hold = 1'b0;
    gen_count++;
  endfunction

  // First n characters of "PING\n"
  function automatic void push_ping(input int n);
    int i;
    for (i = 0; i < n; i++)
      push_rx(PING_TEXT[i*8 +: 8]);
  endfunction

  // AA 55 L body C; lengths of 4 or less carry no body
  function automatic void push_frame(input int len, input bit good, input int fill);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    int         n_body;
    sum    = SYNC_A + SYNC_B + 8'(len);
    n_body = (len <= 4) ? 0 : len - 4;
    push_rx(SYNC_A);
    push_rx(SYNC_B);
    push_rx(8'(len));
    for (i = 0; i < n_body; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(255));
      endcase
      sum = sum + b;
      push_rx(b);
    end
    push_rx(good ? sum : sum + 8'($urandom_range(1, 255)));
  endfunction

  function automatic int frame_len_pick();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return $urandom_range(0, 12);
    else if (r < 93)
      return $urandom_range(13, BUF_DEPTH);
    else
      return $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 20);
  endfunction

  function automatic void build_directed();
    push_ping(5);                          // pong from idle
    push_frame(4, 1'b1, FILL_RANDOM);      // empty good frame
    push_frame(0, 1'b1, FILL_RANDOM);      // length below header size
    push_frame(3, 1'b0, FILL_RANDOM);      // short frame, bad checksum
    push_frame(5, 1'b1, FILL_ZERO);        // single body byte of 00
    gen_hold = 1'b1;                       // drain before the full frame
    push_frame(BUF_DEPTH, 1'b1, FILL_ONES);
    push_frame(10, 1'b0, FILL_RANDOM);     // checksum error
    push_frame(BUF_DEPTH + 1, 1'b1, FILL_RANDOM); // oversize, sum irrelevant
    // AA where 55 belongs: back to hunting, the following 55 is not a header
    push_rx(SYNC_A);
    push_rx(SYNC_A);
    push_rx(SYNC_B);
    push_rx(8'h07);
    push_rx(SYNC_A);
    push_rx(8'h13);
    // PING in the middle of a frame resets the parser
    push_rx(SYNC_A);
    push_rx(SYNC_B);
    push_rx(8'd10);
    push_ping(5);
    push_frame(6, 1'b1, FILL_RANDOM);
    // repeated P restarts the matcher at one
    push_rx(CHAR_P);
    push_ping(5);
    // partial PING followed by a frame
    push_ping(3);
    push_frame(6, 1'b1, FILL_RANDOM);
  endfunction

  // Random traffic fills the item budget; the idling phases split what is left
  function automatic void build_random();
    int         r;
    int         i;
    int         n;
    int         base;
    int         step;
    logic [1:0] ph;
    base = gen_count;
    while (gen_count < NUM_ITEMS) begin
      step = (gen_count - base) * 3 / (NUM_ITEMS - base);
      ph   = (step > 2) ? 2'd2 : 2'(step);
      if (ph != gen_phase) begin
        gen_phase = ph;
        gen_hold  = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 65) begin
        push_frame(frame_len_pick(), $urandom_range(99) < 85, FILL_RANDOM);
      end else if (r < 75) begin
        if ($urandom_range(1))
          push_rx(CHAR_P);
        push_ping(5);
      end else if (r < 87) begin
        // broken sequences
        case ($urandom_range(3))
          0: begin
            push_rx(SYNC_A);
            push_rx(8'($urandom_range(255)));
          end
          1: begin
            push_rx(SYNC_A);
            push_rx(SYNC_A);
            push_rx(SYNC_B);
          end
          2: begin
            // truncated frame, then PING to resynchronise
            push_rx(SYNC_A);
            push_rx(SYNC_B);
            push_rx(8'($urandom_range(5, 30)));
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
              push_rx(8'($urandom_range(255)));
            push_ping(5);
          end
          default: push_ping($urandom_range(1, 4));
        endcase
      end else begin
        // line noise
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          push_rx($urandom_range(3) == 0 ? SYNC_A : 8'($urandom_range(255)));
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Idling profile per phase
  // ---------------------------------------------------------------------

  function automatic int src_idle_pct(input logic [1:0] ph);
    case (ph)
      2'd0:    return 28;
      2'd1:    return 72;
      default: return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(input logic [1:0] ph);
    case (ph)
      2'd0:    return 72;
      2'd1:    return 28;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: a transaction completes on an edge with valid high and stall
  // low; the payload is held while stalled and only replaced once taken
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall)
        parse_rx_byte(rx_byte);
      if (!rx_valid || !rx_stall) begin
        // a held item waits until every outstanding result has come out
        if (rx_pending_q.size() == 0 ||
            $urandom_range(99) < src_idle_pct(cur_phase) ||
            (rx_pending_q[0].hold && frame_result_q.size() != 0)) begin
          rx_valid <= 1'b0;
        end else begin
          drv_item  = rx_pending_q.pop_front();
          rx_valid  <= 1'b1;
          rx_byte   <= drv_item.data;
          cur_phase <= drv_item.phase;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result transaction is checked against the oldest
  // prediction; stall is toggled at random according to the phase
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    deframe_res_t got;
    deframe_res_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        got = {kind, body_byte, position, frame_length, last};
        if (frame_result_q.size() == 0) begin
          err_count++;
          if (err_count <= ERR_SHOWN)
            $display("unexpected result: kind %0d byte %02h pos %0d len %0d last %0d",
                     got.kind, got.body_byte, got.position, got.frame_length, got.last);
        end else begin
          want = frame_result_q.pop_front();
          if (got.kind !== want.kind || got.body_byte !== want.body_byte ||
              got.position !== want.position || got.frame_length !== want.frame_length ||
              got.last !== want.last) begin
            err_count++;
            if (err_count <= ERR_SHOWN)
              $display("mismatch: exp kind %0d byte %02h pos %0d len %0d last %0d, ",
                       want.kind, want.body_byte, want.position, want.frame_length,
                       want.last,
                       "got kind %0d byte %02h pos %0d len %0d last %0d",
                       got.kind, got.body_byte, got.position,
                       got.frame_length, got.last);
          end
        end
      end
      res_stall <= ($urandom_range(99) < sink_stall_pct(cur_phase));
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: build the stimulus, release reset, wait for the drain
  // ---------------------------------------------------------------------

  initial begin
    build_directed();
    build_random();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (rx_pending_q.size() != 0 || rx_valid)
      @(posedge clk);
    while (frame_result_q.size() != 0)
      @(posedge clk);
    // quiet period to catch stray results
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/slcd_pkg.sv
rtl/core/slcd_ram.sv
rtl/core/slcd_ctrl.sv
rtl/core/slcd_datapath.sv
rtl/core/sync_length_checksum_deframer_top.sv
rtl/core/slcd_checker.sv
tb/sync_length_checksum_deframer_top_test.sv
